// File: rtl/ini_tok_pkg.sv
// ============================================================================
// ini_tok_pkg
// Shared types, character codes and result encodings for the INI line
// tokenizer.
// ============================================================================
package ini_tok_pkg;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_TITLE,
        PH_KEY,
        PH_VLEAD,
        PH_VALUE
    } phase_t;

    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    localparam logic       KIND_CHAR    = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;

    localparam logic [1:0] TAG_TITLE = 2'd0;
    localparam logic [1:0] TAG_KEY   = 2'd1;
    localparam logic [1:0] TAG_VALUE = 2'd2;

    localparam logic [1:0] LINE_BLANK   = 2'd0;
    localparam logic [1:0] LINE_SECTION = 2'd1;
    localparam logic [1:0] LINE_KEYVAL  = 2'd2;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_UNTERM   = 2'd1;
    localparam logic [1:0] ERR_NO_EQ    = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [1:0] field_tag;
        logic [7:0] out_char;
        logic [7:0] char_index;
        logic [1:0] line_kind;
        logic [1:0] error_code;
        logic [7:0] title_length;
        logic [7:0] key_length;
        logic [7:0] value_length;
    } result_t;

    typedef struct packed {
        phase_t phase;
        logic   line_end;
    } core_stat_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// File: rtl/ini_tok_core.sv
// ============================================================================
// ini_tok_core
// Per-byte line state and result forming: one character word and/or one
// end-of-line summary word for each byte taken from the input register.
// ============================================================================
module ini_tok_core
    import ini_tok_pkg::*;
#(
    parameter int FIELD_MAX = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       advance,
    output result_t    res0,
    output result_t    res1,
    output logic [1:0] res_cnt,
    output core_stat_t stat
);

    localparam int CW = $clog2(FIELD_MAX);
    localparam logic [CW-1:0] CNT_LIMIT = CW'(FIELD_MAX - 1);

    phase_t        phase_reg, phase_next;
    logic          esc_reg, esc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ktrim_reg, ktrim_next;
    logic [CW-1:0] vtrim_reg, vtrim_next;
    logic [1:0]    err_reg, err_next;
    logic          closed_reg, closed_next;

    logic          is_nl, line_end, b_ws;
    logic          key_proc, val_proc, title_proc, store_req, store_en;
    logic [1:0]    store_tag;
    result_t       char_res, sum_res;

    function automatic logic [7:0] sat8(input logic [CW-1:0] v);
        logic [CW+7:0] w;
        w = {8'd0, v};
        return (w > (CW+8)'(255)) ? 8'hFF : w[7:0];
    endfunction

    function automatic logic [7:0] low8(input logic [CW-1:0] v);
        logic [CW+7:0] w;
        w = {8'd0, v};
        return w[7:0];
    endfunction

    assign is_nl    = (in_byte == CH_NEWLINE);
    assign line_end = is_nl || in_last;
    assign b_ws     = is_ws(in_byte);

    // next line state
    always_comb begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        cnt_next    = cnt_reg;
        ktrim_next  = ktrim_reg;
        vtrim_next  = vtrim_reg;
        err_next    = err_reg;
        closed_next = closed_reg;
        key_proc    = 1'b0;
        val_proc    = 1'b0;
        title_proc  = 1'b0;
        store_req   = 1'b0;
        store_en    = 1'b0;
        store_tag   = TAG_KEY;
        if (!is_nl) begin
            case (phase_reg)
                PH_LEAD: begin
                    if (!b_ws) begin
                        if (in_byte == CH_LBRACK) begin
                            phase_next = PH_TITLE;
                            cnt_next   = '0;
                            vtrim_next = '0;
                        end else begin
                            phase_next = PH_KEY;
                            cnt_next   = '0;
                            ktrim_next = '0;
                            key_proc   = 1'b1;
                        end
                    end
                end
                PH_KEY:   key_proc = 1'b1;
                PH_VLEAD: begin
                    if (!b_ws) begin
                        phase_next = PH_VALUE;
                        val_proc   = 1'b1;
                    end
                end
                PH_VALUE: val_proc = 1'b1;
                PH_TITLE: title_proc = 1'b1;
                default: ;
            endcase
        end

        if (key_proc) begin
            if (!esc_reg && in_byte == CH_BSLASH) begin
                esc_next = 1'b1;
            end else if (!esc_reg && in_byte == CH_EQUALS) begin
                phase_next = PH_VLEAD;
                cnt_next   = '0;
                vtrim_next = '0;
            end else begin
                esc_next  = 1'b0;
                store_req = 1'b1;
                store_tag = TAG_KEY;
            end
        end
        if (val_proc) begin
            if (!esc_reg && in_byte == CH_BSLASH) begin
                esc_next   = 1'b1;
                vtrim_next = cnt_reg;
            end else begin
                esc_next  = 1'b0;
                store_req = 1'b1;
                store_tag = TAG_VALUE;
            end
        end
        if (title_proc && !closed_reg) begin
            if (!esc_reg && in_byte == CH_BSLASH) begin
                esc_next   = 1'b1;
                vtrim_next = cnt_reg;
            end else if (!esc_reg && in_byte == CH_RBRACK) begin
                closed_next = 1'b1;
                vtrim_next  = cnt_reg;
            end else begin
                esc_next  = 1'b0;
                store_req = 1'b1;
                store_tag = TAG_TITLE;
            end
        end

        // full field: drop the character and flag overflow
        if (store_req) begin
            if (cnt_reg >= CNT_LIMIT) begin
                err_next = ERR_OVERFLOW;
            end else begin
                store_en = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (!b_ws) begin
                    if (store_tag == TAG_KEY) begin
                        ktrim_next = cnt_reg + CW'(1);
                    end else begin
                        vtrim_next = cnt_reg + CW'(1);
                    end
                end
            end
        end
    end

    // result words
    always_comb begin
        char_res            = '0;
        char_res.kind       = KIND_CHAR;
        char_res.field_tag  = store_tag;
        char_res.out_char   = in_byte;
        char_res.char_index = low8(cnt_reg);

        sum_res      = '0;
        sum_res.kind = KIND_SUMMARY;
        case (phase_next)
            PH_TITLE: begin
                sum_res.line_kind    = LINE_SECTION;
                sum_res.error_code   = closed_next ? err_next : ERR_UNTERM;
                sum_res.title_length = sat8(vtrim_next);
            end
            PH_KEY: begin
                sum_res.line_kind  = LINE_KEYVAL;
                sum_res.error_code = ERR_NO_EQ;
                sum_res.key_length = sat8(ktrim_next);
            end
            PH_VLEAD, PH_VALUE: begin
                sum_res.line_kind    = LINE_KEYVAL;
                sum_res.error_code   = err_next;
                sum_res.key_length   = sat8(ktrim_next);
                sum_res.value_length = sat8(vtrim_next);
            end
            default: ;
        endcase

        res0    = store_en ? char_res : sum_res;
        res1    = sum_res;
        res_cnt = in_valid ? ({1'b0, store_en} + {1'b0, line_end}) : 2'd0;
    end

    assign stat.phase    = phase_reg;
    assign stat.line_end = line_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEAD;
            esc_reg    <= 1'b0;
            cnt_reg    <= '0;
            ktrim_reg  <= '0;
            vtrim_reg  <= '0;
            err_reg    <= ERR_OK;
            closed_reg <= 1'b0;
        end else if (advance) begin
            if (line_end) begin
                phase_reg  <= PH_LEAD;
                esc_reg    <= 1'b0;
                cnt_reg    <= '0;
                ktrim_reg  <= '0;
                vtrim_reg  <= '0;
                err_reg    <= ERR_OK;
                closed_reg <= 1'b0;
            end else begin
                phase_reg  <= phase_next;
                esc_reg    <= esc_next;
                cnt_reg    <= cnt_next;
                ktrim_reg  <= ktrim_next;
                vtrim_reg  <= vtrim_next;
                err_reg    <= err_next;
                closed_reg <= closed_next;
            end
        end
    end

endmodule

// File: rtl/ini_tok_outq.sv
// ============================================================================
// ini_tok_outq
// Two-entry result queue; takes up to two words per cycle, drives one word.
// ============================================================================
module ini_tok_outq
    import ini_tok_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       out_ready,
    output result_t    head,
    output logic       head_valid,
    output logic [1:0] count
);

    result_t    e0_reg, e0_next;
    result_t    e1_reg, e1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] kept;
    logic       pop;

    assign pop  = (cnt_reg != 2'd0) && out_ready;
    assign kept = cnt_reg - {1'b0, pop};

    always_comb begin
        e0_next = pop ? e1_reg : e0_reg;
        e1_next = e1_reg;
        case (kept)
            2'd0: begin
                if (push_cnt != 2'd0) e0_next = push0;
                if (push_cnt == 2'd2) e1_next = push1;
            end
            2'd1: begin
                if (push_cnt != 2'd0) e1_next = push0;
            end
            default: ;
        endcase
        cnt_next = kept + push_cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign head       = e0_reg;
    assign head_valid = (cnt_reg != 2'd0);
    assign count      = cnt_reg;

endmodule

// File: rtl/ini_line_tokenizer.sv
// ============================================================================
// ini_line_tokenizer
// Streaming tokenizer for one INI line: section title, key and value
// characters with escapes removed, then a per-line summary word.
// ============================================================================
//
//  channel  dir  payload                                      ends word
//  -------  ---  -------------------------------------------  -----------
//  s_       in   tdata: char_byte; tlast: last byte of line   tvalid&tready
//  m_       out  tuser: kind; tdata: tag, char, index, sums   tvalid&tready
//
//  One input word per cycle while the input register is not held. A byte is
//  held in the input register, decoded against the line state and written
//  into a two-entry result queue; its first result word shows on m_ once it
//  is in the queue and can leave from there when m_tready is high.
//  A byte that both stores a character and ends the line yields two words,
//  and the single output port then sets the pace.
//  Reset (aresetn low, synchronous) clears the line state, the input
//  register valid and the queue count. m_tready low stalls the queue; the
//  input register holds until the queue has room for the byte's results.
//
module ini_line_tokenizer
    import ini_tok_pkg::*;
#(
    parameter int FIELD_MAX = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [1:0] field_tag, [9:2] out_char,
                                   // [17:10] char_index, [19:18] line_kind,
                                   // [21:20] error_code, [29:22] title_length,
                                   // [37:30] key_length, [45:38] value_length,
                                   // [47:46] zero
    output logic        m_tuser    // kind
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       advance;
    logic       room;
    logic       pop;
    logic [1:0] push_cnt;
    logic [1:0] res_cnt;
    logic [1:0] q_count;
    result_t    res0, res1, head;
    core_stat_t stat;

    ini_tok_core #(
        .FIELD_MAX (FIELD_MAX)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .in_last  (in_last_reg),
        .advance  (advance),
        .res0     (res0),
        .res1     (res1),
        .res_cnt  (res_cnt),
        .stat     (stat)
    );

    // advance only when the queue, after this cycle's pop, fits all results
    assign pop      = (q_count != 2'd0) && m_tready;
    assign room     = (({1'b0, q_count} - {2'b00, pop} + {1'b0, res_cnt}) <= 3'd2);
    assign advance  = in_valid_reg && room;
    assign push_cnt = advance ? res_cnt : 2'd0;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ini_tok_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (push_cnt),
        .push0      (res0),
        .push1      (res1),
        .out_ready  (m_tready),
        .head       (head),
        .head_valid (m_tvalid),
        .count      (q_count)
    );

    // pack the head word, first field lowest
    assign m_tuser = head.kind;
    assign m_tdata = {2'b00, head.value_length, head.key_length, head.title_length,
                      head.error_code, head.line_kind, head.char_index,
                      head.out_char, head.field_tag};

    // two words from one byte: character first, summary second
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_cnt == 2'd2) |-> (res0.kind == KIND_CHAR && res1.kind == KIND_SUMMARY))
        else $error("two-word byte out of order");

    // a consumed line end leaves the state at the line start
    a_line_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && stat.line_end) |=> (stat.phase == PH_LEAD))
        else $error("line state not cleared after line end");

    // queue never overfills
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count != 2'd3))
        else $error("result queue overfilled");

    // a held byte that cannot advance keeps the input side stalled
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> !s_tready)
        else $error("input taken while byte held");

endmodule
